### rtl/slxfd_pkg.sv
// Shared types and constants for the length-prefixed XOR-checked frame deframer.
`default_nettype none

package slxfd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned KIND_W      = 2;
    localparam int unsigned APB_DATA_W  = 32;
    localparam int unsigned APB_ADDR_W  = 3;

    localparam logic [BYTE_W-1:0] START_BYTE_RST   = 8'hEF;
    localparam logic [BYTE_W-1:0] LENGTH_LIMIT_RST = 8'd254;

    localparam logic REG_START_BYTE   = 1'b0;
    localparam logic REG_LENGTH_LIMIT = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        EV_PAYLOAD = 2'd0,
        EV_GOOD    = 2'd1,
        EV_BADCHK  = 2'd2,
        EV_REJECT  = 2'd3
    } event_kind_t;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_LEN   = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CHECK = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] length_limit;
    } cfg_t;

endpackage

`default_nettype wire

### rtl/sop_len_xor_frame_deframer.sv
// Top level of the length-prefixed frame deframer with XOR check byte.
//
// Takes one received byte per transaction and accepts a new byte every cycle
// while input stall is low. A byte is registered in the input register on
// acceptance and runs through the frame state machine from there; its result,
// if any, loads into the output register once that register is free, and is
// offered from the output register until taken. Throughput is one byte per
// clock while input stall is low.
// Input stall rises only when a byte that yields a result cannot move into an
// output register that is still held by a stalled result transaction.
`default_nettype none

module sop_len_xor_frame_deframer (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [slxfd_pkg::APB_ADDR_W-1:0] paddr,
    input  wire logic [slxfd_pkg::APB_DATA_W-1:0] pwdata,
    output logic      [slxfd_pkg::APB_DATA_W-1:0] prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [slxfd_pkg::KIND_W-1:0]    event_kind,
    output logic      [slxfd_pkg::BYTE_W-1:0]    payload_byte,
    output logic      [slxfd_pkg::BYTE_W-1:0]    byte_index,
    output logic      [slxfd_pkg::BYTE_W-1:0]    frame_length,
    output logic      [slxfd_pkg::BYTE_W-1:0]    received_check
);
    import slxfd_pkg::*;

    cfg_t cfg;

    slxfd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    slxfd_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length),
        .received_check (received_check)
    );

endmodule

`default_nettype wire

### rtl/slxfd_regs.sv
// APB configuration registers: start byte and length limit.
`default_nettype none

module slxfd_regs (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [slxfd_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [slxfd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [slxfd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                    pready,
    output slxfd_pkg::cfg_t                         cfg
);
    import slxfd_pkg::*;

    logic [BYTE_W-1:0] start_byte_reg;
    logic [BYTE_W-1:0] length_limit_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_byte_reg   <= START_BYTE_RST;
            length_limit_reg <= LENGTH_LIMIT_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_START_BYTE:   start_byte_reg   <= pwdata[BYTE_W-1:0];
                REG_LENGTH_LIMIT: length_limit_reg <= pwdata[BYTE_W-1:0];
                default:          start_byte_reg   <= start_byte_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_sel)
            REG_START_BYTE:   prdata[BYTE_W-1:0] = start_byte_reg;
            REG_LENGTH_LIMIT: prdata[BYTE_W-1:0] = length_limit_reg;
            default:          prdata = '0;
        endcase
    end

    assign cfg.start_byte   = start_byte_reg;
    assign cfg.length_limit = length_limit_reg;

endmodule

`default_nettype wire

### rtl/slxfd_core.sv
// Deframing datapath: input register, frame state machine and result register.
`default_nettype none

module slxfd_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  slxfd_pkg::cfg_t                      cfg,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    rx_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [slxfd_pkg::KIND_W-1:0]    event_kind,
    output logic      [slxfd_pkg::BYTE_W-1:0]    payload_byte,
    output logic      [slxfd_pkg::BYTE_W-1:0]    byte_index,
    output logic      [slxfd_pkg::BYTE_W-1:0]    frame_length,
    output logic      [slxfd_pkg::BYTE_W-1:0]    received_check
);
    import slxfd_pkg::*;

    logic              ib_valid_reg;
    logic [BYTE_W-1:0] ib_byte_reg;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] length_reg, length_next;
    logic [BYTE_W-1:0] seen_reg, seen_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;
    logic [BYTE_W-1:0] seen_inc;

    logic              res_valid;
    event_kind_t       res_kind;
    logic [BYTE_W-1:0] res_pay;
    logic [BYTE_W-1:0] res_idx;
    logic [BYTE_W-1:0] res_flen;
    logic [BYTE_W-1:0] res_chk;

    logic              ob_valid_reg;
    event_kind_t       ob_kind_reg;
    logic [BYTE_W-1:0] ob_pay_reg;
    logic [BYTE_W-1:0] ob_idx_reg;
    logic [BYTE_W-1:0] ob_flen_reg;
    logic [BYTE_W-1:0] ob_chk_reg;

    logic              ob_free;
    logic              proc_fire;
    logic              in_fire;

    assign ob_free   = !ob_valid_reg || !out_stall;
    assign proc_fire = ib_valid_reg && (!res_valid || ob_free);
    assign in_stall  = ib_valid_reg && !proc_fire;
    assign in_fire   = in_valid && !in_stall;
    assign seen_inc  = seen_reg + BYTE_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        seen_next   = seen_reg;
        xor_next    = xor_reg;
        res_valid   = 1'b0;
        res_kind    = EV_PAYLOAD;
        res_pay     = '0;
        res_idx     = '0;
        res_flen    = '0;
        res_chk     = '0;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (ib_byte_reg == cfg.start_byte)
                    phase_next = PH_LEN;
            end
            PH_LEN:
            begin
                if (ib_byte_reg > cfg.length_limit)
                begin
                    phase_next = PH_HUNT;
                    res_valid  = 1'b1;
                    res_kind   = EV_REJECT;
                    res_flen   = ib_byte_reg;
                end
                else
                begin
                    length_next = ib_byte_reg;
                    seen_next   = '0;
                    xor_next    = ib_byte_reg;
                    phase_next  = (ib_byte_reg == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                res_valid = 1'b1;
                res_kind  = EV_PAYLOAD;
                res_pay   = ib_byte_reg;
                res_idx   = seen_reg;
                res_flen  = length_reg;
                xor_next  = xor_reg ^ ib_byte_reg;
                seen_next = seen_inc;
                if (seen_inc == length_reg)
                    phase_next = PH_CHECK;
            end
            PH_CHECK:
            begin
                phase_next = PH_HUNT;
                res_valid  = 1'b1;
                res_kind   = (ib_byte_reg == xor_reg) ? EV_GOOD : EV_BADCHK;
                res_flen   = length_reg;
                res_chk    = ib_byte_reg;
            end
            default:
            begin
                phase_next = PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ib_valid_reg <= 1'b0;
            phase_reg    <= PH_HUNT;
            length_reg   <= '0;
            seen_reg     <= '0;
            xor_reg      <= '0;
            ob_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
                ib_valid_reg <= 1'b1;
            else if (proc_fire)
                ib_valid_reg <= 1'b0;
            if (proc_fire)
            begin
                phase_reg  <= phase_next;
                length_reg <= length_next;
                seen_reg   <= seen_next;
                xor_reg    <= xor_next;
            end
            if (proc_fire && res_valid)
                ob_valid_reg <= 1'b1;
            else if (!out_stall)
                ob_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            ib_byte_reg <= rx_byte;
        if (proc_fire && res_valid)
        begin
            ob_kind_reg <= res_kind;
            ob_pay_reg  <= res_pay;
            ob_idx_reg  <= res_idx;
            ob_flen_reg <= res_flen;
            ob_chk_reg  <= res_chk;
        end
    end

    assign out_valid      = ob_valid_reg;
    assign event_kind     = ob_kind_reg;
    assign payload_byte   = ob_pay_reg;
    assign byte_index     = ob_idx_reg;
    assign frame_length   = ob_flen_reg;
    assign received_check = ob_chk_reg;

endmodule

`default_nettype wire

### rtl/slxfd_checker.sv
// Port-level checker for the frame deframer and its bind to the top level.
`default_nettype none

module slxfd_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  wire logic [slxfd_pkg::KIND_W-1:0]    event_kind,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    payload_byte,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    byte_index,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    frame_length,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]    received_check
);
    import slxfd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_payload_no_check: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_PAYLOAD |-> received_check == '0)
        else $error("payload result carries a check byte");

    a_end_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind != EV_PAYLOAD |-> payload_byte == '0 && byte_index == '0)
        else $error("frame-end result carries payload fields");

    a_index_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_kind == EV_PAYLOAD |-> byte_index < frame_length)
        else $error("payload index beyond frame length");

endmodule

bind sop_len_xor_frame_deframer slxfd_checker u_slxfd_checker (.*);

`default_nettype wire

### verif/frame_event_checker.sv
// Checker that predicts and compares deframer result transactions.
`default_nettype none

module frame_event_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic                              pready,
    input  wire logic [slxfd_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [slxfd_pkg::APB_DATA_W-1:0]  pwdata,
    input  wire logic                              in_valid,
    input  wire logic                              in_stall,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]      rx_byte,
    input  wire logic                              out_valid,
    input  wire logic                              out_stall,
    input  wire logic [slxfd_pkg::KIND_W-1:0]      event_kind,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]      payload_byte,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]      byte_index,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]      frame_length,
    input  wire logic [slxfd_pkg::BYTE_W-1:0]      received_check,
    output int                                     fail_count,
    output int                                     pending_count,
    output int                                     bytes_taken,
    output int                                     payload_events,
    output int                                     good_frames,
    output int                                     bad_frames,
    output int                                     rejected_lengths
);

    import slxfd_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        event_kind_t       kind;
        logic [BYTE_W-1:0] payload;
        logic [BYTE_W-1:0] index;
        logic [BYTE_W-1:0] length;
        logic [BYTE_W-1:0] check;
    } frame_event_t;

    cfg_t              settings;
    phase_t            phase;
    logic [BYTE_W-1:0] held_length;
    logic [BYTE_W-1:0] seen_count;
    logic [BYTE_W-1:0] xor_acc;
    frame_event_t      expected_events[$];

    function automatic void push_event(input event_kind_t kind,
                                       input logic [BYTE_W-1:0] payload,
                                       input logic [BYTE_W-1:0] index,
                                       input logic [BYTE_W-1:0] length,
                                       input logic [BYTE_W-1:0] check);
        frame_event_t ev;
        ev.kind    = kind;
        ev.payload = payload;
        ev.index   = index;
        ev.length  = length;
        ev.check   = check;
        expected_events.push_back(ev);
    endfunction

    function automatic void predict_byte(input logic [BYTE_W-1:0] b);
        case (phase)
            PH_HUNT:
            begin
                if (b == settings.start_byte)
                    phase = PH_LEN;
            end
            PH_LEN:
            begin
                if (b > settings.length_limit)
                begin
                    phase = PH_HUNT;
                    push_event(EV_REJECT, '0, '0, b, '0);
                end
                else
                begin
                    held_length = b;
                    seen_count  = '0;
                    xor_acc     = b;
                    phase       = (b == '0) ? PH_CHECK : PH_DATA;
                end
            end
            PH_DATA:
            begin
                push_event(EV_PAYLOAD, b, seen_count, held_length, '0);
                xor_acc    = xor_acc ^ b;
                seen_count = seen_count + 1'b1;
                if (seen_count == held_length)
                    phase = PH_CHECK;
            end
            default:
            begin
                phase = PH_HUNT;
                if (b == xor_acc)
                    push_event(EV_GOOD, '0, '0, held_length, b);
                else
                    push_event(EV_BADCHK, '0, '0, held_length, b);
            end
        endcase
    endfunction

    function automatic void compare_event();
        frame_event_t got;
        frame_event_t want;
        got.kind    = event_kind_t'(event_kind);
        got.payload = payload_byte;
        got.index   = byte_index;
        got.length  = frame_length;
        got.check   = received_check;
        case (got.kind)
            EV_PAYLOAD: payload_events++;
            EV_GOOD:    good_frames++;
            EV_BADCHK:  bad_frames++;
            default:    rejected_lengths++;
        endcase
        if (expected_events.size() == 0)
        begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
                $display("unexpected result: kind=%0d pay=%h idx=%0d len=%0d chk=%h",
                         got.kind, got.payload, got.index, got.length, got.check);
        end
        else
        begin
            want = expected_events.pop_front();
            if (got.kind != want.kind || got.payload != want.payload ||
                got.index != want.index || got.length != want.length ||
                got.check != want.check)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                begin
                    $display("result differs: expected kind=%0d pay=%h idx=%0d len=%0d chk=%h",
                             want.kind, want.payload, want.index, want.length, want.check);
                    $display("                actual   kind=%0d pay=%h idx=%0d len=%0d chk=%h",
                             got.kind, got.payload, got.index, got.length, got.check);
                end
            end
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.start_byte   = START_BYTE_RST;
            settings.length_limit = LENGTH_LIMIT_RST;
            phase                 = PH_HUNT;
            held_length           = '0;
            seen_count            = '0;
            xor_acc               = '0;
            expected_events.delete();
            fail_count            = 0;
            pending_count         = 0;
            bytes_taken           = 0;
            payload_events        = 0;
            good_frames           = 0;
            bad_frames            = 0;
            rejected_lengths      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr)
                    {REG_START_BYTE, 2'b00}:
                        settings.start_byte = pwdata[BYTE_W-1:0];
                    {REG_LENGTH_LIMIT, 2'b00}:
                        settings.length_limit = pwdata[BYTE_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && !out_stall)
                compare_event();
            if (in_valid && !in_stall)
            begin
                bytes_taken++;
                predict_byte(rx_byte);
            end
            pending_count = expected_events.size();
        end
    end

endmodule

`default_nettype wire

### verif/tb.sv
// Testbench top: stimulus, idling control and verdict for the frame deframer.
`default_nettype none

module tb;

    import slxfd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 70;
    localparam int HOLD_OFF_CYCLES = 300;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid;
    logic                  in_stall;
    logic [BYTE_W-1:0]     rx_byte;
    logic                  out_valid;
    logic                  out_stall;
    logic [KIND_W-1:0]     event_kind;
    logic [BYTE_W-1:0]     payload_byte;
    logic [BYTE_W-1:0]     byte_index;
    logic [BYTE_W-1:0]     frame_length;
    logic [BYTE_W-1:0]     received_check;

    int fail_count;
    int pending_count;
    int bytes_taken;
    int payload_events;
    int good_frames;
    int bad_frames;
    int rejected_lengths;

    int                send_idle_pct;
    int                recv_stall_pct;
    int                hold_off_cycles;
    int                cycle_count;
    int                frame_bytes;
    logic [BYTE_W-1:0] cur_start;
    logic [BYTE_W-1:0] cur_limit;

    sop_len_xor_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_kind     (event_kind),
        .payload_byte   (payload_byte),
        .byte_index     (byte_index),
        .frame_length   (frame_length),
        .received_check (received_check)
    );

    frame_event_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .pready           (pready),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .rx_byte          (rx_byte),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .event_kind       (event_kind),
        .payload_byte     (payload_byte),
        .byte_index       (byte_index),
        .frame_length     (frame_length),
        .received_check   (received_check),
        .fail_count       (fail_count),
        .pending_count    (pending_count),
        .bytes_taken      (bytes_taken),
        .payload_events   (payload_events),
        .good_frames      (good_frames),
        .bad_frames       (bad_frames),
        .rejected_lengths (rejected_lengths)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold_off_cycles) @(negedge clk);
                hold_off_cycles = 0;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles with %0d results outstanding",
                 cycle_count, pending_count);
        $display("Mismatches found");
        $finish;
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, value};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic send_frame(input logic [BYTE_W-1:0] len, input bit corrupt,
                              input bit truncate);
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] b;
        int                count;
        send_byte(cur_start);
        send_byte(len);
        acc   = len;
        count = truncate ? len / 2 : len;
        for (int i = 0; i < count; i++)
        begin
            b   = 8'($urandom_range(255));
            acc = acc ^ b;
            send_byte(b);
        end
        if (!truncate)
            send_byte(corrupt ? acc ^ 8'($urandom_range(255, 1)) : acc);
        frame_bytes += count + (truncate ? 2 : 3);
    endtask

    task automatic send_reject();
        send_byte(cur_start);
        send_byte(8'($urandom_range(255, cur_limit + 1)));
        frame_bytes += 2;
    endtask

    task automatic send_noise();
        logic [BYTE_W-1:0] b;
        b = 8'($urandom_range(255));
        if (b == cur_start)
            b = ~b;
        send_byte(b);
    endtask

    function automatic logic [BYTE_W-1:0] pick_length();
        int top;
        top = (cur_limit < 12) ? cur_limit : 12;
        if ($urandom_range(49) == 0)
            return cur_limit;
        return 8'($urandom_range(top));
    endfunction

    task automatic run_random(input int quota);
        int start_count;
        int r;
        start_count = frame_bytes;
        while (frame_bytes - start_count < quota)
        begin
            r = $urandom_range(99);
            if (r < 10)
                send_noise();
            else if (r < 18 && cur_limit != 8'hFF)
                send_reject();
            else if (r < 22)
                send_frame(pick_length(), 1'b0, 1'b1);
            else
                send_frame(pick_length(), r < 40, 1'b0);
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        frame_bytes = 0;
        cur_start   = START_BYTE_RST;
        cur_limit   = LENGTH_LIMIT_RST;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_frame(8'd0, 1'b0, 1'b0);
        send_frame(8'd0, 1'b1, 1'b0);
        send_byte(cur_start);
        send_byte(8'd1);
        send_byte(8'hFF);
        send_byte(8'hFE);
        send_byte(cur_start);
        send_byte(8'd2);
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(cur_start);
        send_byte(8'hFF);
        send_frame(8'd1, 1'b0, 1'b0);
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 64;
                    recv_stall_pct = 0;
                    cur_start      = 8'h00;
                    cur_limit      = 8'h00;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 64;
                    cur_start      = 8'hFF;
                    cur_limit      = 8'hFF;
                end
                default:
                begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                    cur_start      = 8'($urandom_range(255));
                    cur_limit      = 8'($urandom_range(40, 1));
                end
            endcase
            if (p != 0)
            begin
                write_reg(REG_START_BYTE, cur_start);
                write_reg(REG_LENGTH_LIMIT, cur_limit);
            end
            if (p == 0)
            begin
                hold_off_cycles = HOLD_OFF_CYCLES;
                send_frame(8'd60, 1'b0, 1'b0);
                drain();
                send_frame(8'd254, 1'b0, 1'b0);
            end
            if (p == 2)
                send_frame(8'd255, 1'b1, 1'b0);
            run_random(ITEMS_PER_PHASE);
            drain();
        end

        repeat (8) @(negedge clk);
        $display("Covered %0d accepted bytes, %0d payload, %0d good, %0d bad-check, %0d rejected",
                 bytes_taken, payload_events, good_frames, bad_frames, rejected_lengths);
        $display("Start byte and length limit swept through both extremes under four idle mixes");
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

### sop_len_xor_frame_deframer.f
rtl/slxfd_pkg.sv
rtl/slxfd_regs.sv
rtl/slxfd_core.sv
rtl/sop_len_xor_frame_deframer.sv
rtl/slxfd_checker.sv
verif/frame_event_checker.sv
verif/tb.sv
